### rtl/core/rspl_pkg.sv
// shared types and constants of the polyline resampler
// no dependencies
package rspl_pkg;

   localparam int COORD_W    = 32;
   localparam int FRAC_BITS  = 12;
   localparam int STEP_W     = 31;
   localparam int TOL_W      = 16;
   localparam int NUM_W      = 16;
   localparam int MAG_W      = 33;
   localparam int LEN_W      = 34;
   localparam int TOT_W      = 35;
   localparam int RAD_W      = 68;
   localparam int ROOT_STEPS = RAD_W / 2;
   localparam int MAX_POINTS = 62;
   localparam int CNT_W      = 6;
   localparam int LO_W       = 18;
   localparam int PROD_W     = 68;
   localparam int QUO_W      = MAG_W;
   localparam int HI_W       = TOT_W - LO_W;

   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1 << FRAC_BITS);
   localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(1);

   typedef enum logic {
      CSR_STEP_INTERVAL = 1'b0,
      CSR_ZERO_TOL      = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic              seg;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [NUM_W-1:0]   start_num;
      logic [MAG_W-1:0]   mag_x;
      logic               neg_x;
      logic [MAG_W-1:0]   mag_y;
      logic               neg_y;
      logic [LEN_W-1:0]   len;
      logic [TOT_W-1:0]   s_first;
      logic [STEP_W-1:0]  step;
      logic [CNT_W-1:0]   count;
      logic               ovf;
      logic               fin;
      logic [COORD_W-1:0] fin_x;
      logic [COORD_W-1:0] fin_y;
      logic [NUM_W-1:0]   fin_num;
   } job_type;

endpackage

### rtl/core/rspl_vertex_if.sv
// vertex channel: valid, ready and one polyline vertex
// depends on rspl_pkg
interface rspl_vertex_if;
   logic                                valid;
   logic                                ready;
   logic signed [rspl_pkg::COORD_W-1:0] x_coord;
   logic signed [rspl_pkg::COORD_W-1:0] y_coord;
   logic signed [rspl_pkg::COORD_W-1:0] z_coord;
   logic                                final_vertex;

   modport source (output valid, x_coord, y_coord, z_coord, final_vertex, input ready);
   modport sink   (input valid, x_coord, y_coord, z_coord, final_vertex, output ready);
endinterface

### rtl/core/rspl_point_if.sv
// point channel: valid, ready and one resampled point
// depends on rspl_pkg
interface rspl_point_if;
   logic                                valid;
   logic                                ready;
   logic signed [rspl_pkg::COORD_W-1:0] out_x;
   logic signed [rspl_pkg::COORD_W-1:0] out_y;
   logic                                is_vertex;
   logic [rspl_pkg::NUM_W-1:0]          vertex_number;
   logic                                cap_overflow;
   logic                                last_of_run;

   modport source (output valid, out_x, out_y, is_vertex, vertex_number, cap_overflow,
                   last_of_run, input ready);
   modport sink   (input valid, out_x, out_y, is_vertex, vertex_number, cap_overflow,
                   last_of_run, output ready);
endinterface

### rtl/core/polyline_fixed_step_resampler_core.sv
// Fixed-step polyline resampler. One vertex beat is taken at a time by the front end, which
// handles a vertex that closes a segment longer than the tolerance in the steps accept, three
// squaring steps, a bit-serial square root, a check step, two restoring divides for residue
// and point count, and a push step; a vertex that closes a segment no longer than the
// tolerance skips the divides, and the first vertex of a polyline goes from accept to the
// check and push steps; each may wait on a full queue. A two-entry queue feeds the back end,
// which registers a job as it pops it and offers it as its first beat, offers a final vertex
// beat in the cycle after the last point is taken, and builds each interpolated point from
// partial products, their sum, a divide for both axes and a send; every beat also waits on ready.
// top level: front end, job queue and back end
// depends on rspl_pkg, rspl_vertex_if, rspl_point_if, rspl_front, rspl_queue, rspl_back
module polyline_fixed_step_resampler_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic                        csr_index,
   input  logic [rspl_pkg::STEP_W-1:0] csr_write_data,
   rspl_vertex_if.sink                 req_chan,
   rspl_point_if.source                rsp_chan
);
   import rspl_pkg::*;

   job_type job_in, job_out;
   logic    job_push, job_full, job_pop, job_empty;

   rspl_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req              (req_chan),
      .job_in           (job_in),
      .job_push         (job_push),
      .job_full         (job_full)
   );

   rspl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_data (job_in),
      .push      (job_push),
      .full      (job_full),
      .pop_data  (job_out),
      .pop       (job_pop),
      .empty     (job_empty)
   );

   rspl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_out   (job_out),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .rsp       (rsp_chan)
   );

endmodule

### rtl/core/rspl_front.sv
// front end: takes vertices, computes segment length, residue and point count
// depends on rspl_pkg and rspl_vertex_if
module rspl_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [rspl_pkg::STEP_W-1:0]   csr_write_data,
   rspl_vertex_if.sink                   req,
   output rspl_pkg::job_type             job_in,
   output logic                          job_push,
   input  logic                          job_full
);
   import rspl_pkg::*;

   typedef enum logic [2:0] {
      F_IDLE, F_SQUARE, F_ROOT, F_CHECK, F_MOD, F_DIV, F_PUSH
   } state_type;

   state_type           state_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [TOL_W-1:0]    tol_ff;
   logic [COORD_W-1:0]  prev_x_ff, prev_y_ff, prev_z_ff;
   logic [STEP_W-1:0]   residue_ff;
   logic [NUM_W-1:0]    counter_ff;
   logic                have_prev_ff;
   logic [COORD_W-1:0]  cur_x_ff, cur_y_ff, cur_z_ff;
   logic                last_ff;
   logic [MAG_W-1:0]    mag_x_ff, mag_y_ff, mag_z_ff;
   logic                neg_x_ff, neg_y_ff;
   logic [1:0]          sq_idx_ff;
   logic [RAD_W-1:0]    rad_ff;
   logic [LEN_W-1:0]    root_ff;
   logic [LEN_W+2:0]    rrem_ff;
   logic [5:0]          iter_ff;
   logic                seg_ff;
   logic [STEP_W-1:0]   step_eff_ff;
   logic [TOT_W-1:0]    dnum_ff;
   logic [STEP_W:0]     drem_ff;
   logic [STEP_W-1:0]   res_ff;
   job_type             job_ff;

   logic [MAG_W-1:0]    dx, dy, dz;
   logic [MAG_W-1:0]    sq_sel;
   logic [2*MAG_W-1:0]  sq;
   logic [LEN_W+2:0]    rtrial, rshift;
   logic                rge;
   logic [STEP_W:0]     dshift;
   logic                dge;
   logic [TOT_W-1:0]    n_q, avail;
   logic                j0;
   logic                ovf;

   assign dx = {req.x_coord[COORD_W-1], req.x_coord} - {prev_x_ff[COORD_W-1], prev_x_ff};
   assign dy = {req.y_coord[COORD_W-1], req.y_coord} - {prev_y_ff[COORD_W-1], prev_y_ff};
   assign dz = {req.z_coord[COORD_W-1], req.z_coord} - {prev_z_ff[COORD_W-1], prev_z_ff};

   always_comb begin
      unique case (sq_idx_ff)
         2'd0:    sq_sel = mag_x_ff;
         2'd1:    sq_sel = mag_y_ff;
         default: sq_sel = mag_z_ff;
      endcase
   end
   assign sq = sq_sel * sq_sel;

   assign rshift = {rrem_ff[LEN_W:0], rad_ff[RAD_W-1 -: 2]};
   assign rtrial = {1'b0, root_ff, 2'b01};
   assign rge    = rshift >= rtrial;

   assign dshift = {drem_ff[STEP_W-1:0], dnum_ff[TOT_W-1]};
   assign dge    = dshift >= {1'b0, step_eff_ff};

   assign n_q   = {dnum_ff[TOT_W-2:0], dge};
   assign j0    = (res_ff == '0);
   assign avail = (n_q > TOT_W'(j0)) ? n_q - TOT_W'(j0) : '0;
   assign ovf   = avail > TOT_W'(MAX_POINTS);

   assign req.ready = (state_ff == F_IDLE);
   assign job_in    = job_ff;
   assign job_push  = (state_ff == F_PUSH) && !job_full && (job_ff.seg || job_ff.fin);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= F_IDLE;
         step_ff      <= STEP_RESET;
         tol_ff       <= TOL_RESET;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_z_ff    <= '0;
         residue_ff   <= '0;
         counter_ff   <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_STEP_INTERVAL: step_ff <= csr_write_data;
               CSR_ZERO_TOL:      tol_ff  <= csr_write_data[TOL_W-1:0];
            endcase
         end
         unique case (state_ff)
            F_IDLE: begin
               if (req.valid) begin
                  cur_x_ff    <= req.x_coord;
                  cur_y_ff    <= req.y_coord;
                  cur_z_ff    <= req.z_coord;
                  last_ff     <= req.final_vertex;
                  neg_x_ff    <= dx[MAG_W-1];
                  neg_y_ff    <= dy[MAG_W-1];
                  mag_x_ff    <= dx[MAG_W-1] ? -dx : dx;
                  mag_y_ff    <= dy[MAG_W-1] ? -dy : dy;
                  mag_z_ff    <= dz[MAG_W-1] ? -dz : dz;
                  sq_idx_ff   <= 2'd0;
                  rad_ff      <= '0;
                  seg_ff      <= 1'b0;
                  step_eff_ff <= (step_ff == '0) ? STEP_W'(1) : step_ff;
                  state_ff    <= have_prev_ff ? F_SQUARE : F_CHECK;
               end
            end
            F_SQUARE: begin
               rad_ff    <= rad_ff + RAD_W'(sq);
               sq_idx_ff <= sq_idx_ff + 2'd1;
               if (sq_idx_ff == 2'd2) begin
                  root_ff  <= '0;
                  rrem_ff  <= '0;
                  iter_ff  <= 6'(ROOT_STEPS - 1);
                  state_ff <= F_ROOT;
               end
            end
            F_ROOT: begin
               rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
               root_ff <= {root_ff[LEN_W-2:0], rge};
               rrem_ff <= rge ? rshift - rtrial : rshift;
               iter_ff <= iter_ff - 6'd1;
               if (iter_ff == '0) begin
                  seg_ff   <= have_prev_ff;
                  state_ff <= F_CHECK;
               end
            end
            F_CHECK: begin
               if (seg_ff && (root_ff > LEN_W'(tol_ff))) begin
                  dnum_ff  <= TOT_W'(residue_ff);
                  drem_ff  <= '0;
                  iter_ff  <= 6'(TOT_W - 1);
                  state_ff <= F_MOD;
               end else begin
                  seg_ff   <= 1'b0;
                  state_ff <= F_PUSH;
               end
               job_ff.seg       <= 1'b0;
               job_ff.start_x   <= prev_x_ff;
               job_ff.start_y   <= prev_y_ff;
               job_ff.start_num <= counter_ff - NUM_W'(1);
               job_ff.mag_x     <= mag_x_ff;
               job_ff.neg_x     <= neg_x_ff;
               job_ff.mag_y     <= mag_y_ff;
               job_ff.neg_y     <= neg_y_ff;
               job_ff.len       <= root_ff;
               job_ff.step      <= step_eff_ff;
               job_ff.count     <= '0;
               job_ff.ovf       <= 1'b0;
               job_ff.s_first   <= '0;
               job_ff.fin       <= last_ff;
               job_ff.fin_x     <= cur_x_ff;
               job_ff.fin_y     <= cur_y_ff;
               job_ff.fin_num   <= counter_ff;
            end
            F_MOD: begin
               dnum_ff <= {dnum_ff[TOT_W-2:0], dge};
               drem_ff <= dge ? dshift - {1'b0, step_eff_ff} : dshift;
               iter_ff <= iter_ff - 6'd1;
               if (iter_ff == '0) begin
                  res_ff   <= dge ? STEP_W'(dshift - {1'b0, step_eff_ff})
                                  : STEP_W'(dshift);
                  dnum_ff  <= TOT_W'(root_ff) +
                              TOT_W'(dge ? STEP_W'(dshift - {1'b0, step_eff_ff})
                                         : STEP_W'(dshift));
                  drem_ff  <= '0;
                  iter_ff  <= 6'(TOT_W - 1);
                  state_ff <= F_DIV;
               end
            end
            F_DIV: begin
               dnum_ff <= {dnum_ff[TOT_W-2:0], dge};
               drem_ff <= dge ? dshift - {1'b0, step_eff_ff} : dshift;
               iter_ff <= iter_ff - 6'd1;
               if (iter_ff == '0) begin
                  job_ff.seg     <= 1'b1;
                  job_ff.ovf     <= ovf;
                  job_ff.count   <= ovf ? CNT_W'(MAX_POINTS) : avail[CNT_W-1:0];
                  job_ff.s_first <= TOT_W'(step_eff_ff) - TOT_W'(res_ff) +
                                    (j0 ? TOT_W'(step_eff_ff) : '0);
                  state_ff       <= F_PUSH;
               end
            end
            F_PUSH: begin
               if (!job_full || !(job_ff.seg || job_ff.fin)) begin
                  if (last_ff) begin
                     prev_x_ff    <= '0;
                     prev_y_ff    <= '0;
                     prev_z_ff    <= '0;
                     residue_ff   <= '0;
                     counter_ff   <= '0;
                     have_prev_ff <= 1'b0;
                  end else begin
                     prev_x_ff    <= cur_x_ff;
                     prev_y_ff    <= cur_y_ff;
                     prev_z_ff    <= cur_z_ff;
                     counter_ff   <= counter_ff + NUM_W'(1);
                     have_prev_ff <= 1'b1;
                     if (seg_ff) begin
                        residue_ff <= drem_ff[STEP_W-1:0];
                     end
                  end
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

### rtl/core/rspl_queue.sv
// two-entry job queue between front and back ends
// depends on rspl_pkg
module rspl_queue (
   input  logic              clock,
   input  logic              reset,
   input  rspl_pkg::job_type push_data,
   input  logic              push,
   output logic              full,
   output rspl_pkg::job_type pop_data,
   input  logic              pop,
   output logic              empty
);
   import rspl_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff;

   assign full     = (fill_ff == 2'd2);
   assign empty    = (fill_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         if (push && !full) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop && !empty) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         fill_ff <= fill_ff + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
      end
   end

endmodule

### rtl/core/rspl_back.sv
// back end: emits start vertex, interpolated points and final vertex of a job
// depends on rspl_pkg and rspl_point_if
module rspl_back (
   input  logic              clock,
   input  logic              reset,
   input  rspl_pkg::job_type job_out,
   input  logic              job_empty,
   output logic              job_pop,
   rspl_point_if.source      rsp
);
   import rspl_pkg::*;

   typedef enum logic [2:0] {
      B_IDLE, B_MUL0, B_MUL1, B_DIV, B_SEND
   } state_type;

   state_type             state_ff;
   job_type               job_ff;
   logic [CNT_W-1:0]      left_ff;
   logic                  fin_pend_ff;
   logic [TOT_W-1:0]      s_ff;
   logic [MAG_W+LO_W-1:0] plo_x_ff, plo_y_ff;
   logic [MAG_W+HI_W-1:0] phi_x_ff, phi_y_ff;
   logic [LEN_W-1:0]      rem_x_ff, rem_y_ff;
   logic [QUO_W-1:0]      sh_x_ff, sh_y_ff;
   logic [5:0]            iter_ff;
   logic [COORD_W-1:0]    out_x_ff, out_y_ff;
   logic                  is_vertex_ff, ovf_ff, last_ff;
   logic [NUM_W-1:0]      num_ff;

   logic [PROD_W-1:0]     num_x, num_y;
   logic [LEN_W:0]        shx, shy;
   logic                  gex, gey;
   logic [QUO_W-1:0]      qx, qy;

   assign num_x = PROD_W'(plo_x_ff) + (PROD_W'(phi_x_ff) << LO_W) + PROD_W'(job_ff.len >> 1);
   assign num_y = PROD_W'(plo_y_ff) + (PROD_W'(phi_y_ff) << LO_W) + PROD_W'(job_ff.len >> 1);
   assign shx   = {rem_x_ff, sh_x_ff[QUO_W-1]};
   assign shy   = {rem_y_ff, sh_y_ff[QUO_W-1]};
   assign gex   = shx >= {1'b0, job_ff.len};
   assign gey   = shy >= {1'b0, job_ff.len};
   assign qx    = {sh_x_ff[QUO_W-2:0], gex};
   assign qy    = {sh_y_ff[QUO_W-2:0], gey};

   assign job_pop           = (state_ff == B_IDLE) && !job_empty;
   assign rsp.valid         = (state_ff == B_SEND);
   assign rsp.out_x         = out_x_ff;
   assign rsp.out_y         = out_y_ff;
   assign rsp.is_vertex     = is_vertex_ff;
   assign rsp.vertex_number = num_ff;
   assign rsp.cap_overflow  = ovf_ff;
   assign rsp.last_of_run   = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         unique case (state_ff)
            B_IDLE: begin
               if (!job_empty) begin
                  job_ff       <= job_out;
                  left_ff      <= job_out.count;
                  s_ff         <= job_out.s_first;
                  ovf_ff       <= job_out.ovf;
                  is_vertex_ff <= 1'b1;
                  if (job_out.seg) begin
                     out_x_ff    <= job_out.start_x;
                     out_y_ff    <= job_out.start_y;
                     num_ff      <= job_out.start_num;
                     last_ff     <= (job_out.count == '0) && !job_out.fin;
                     fin_pend_ff <= job_out.fin;
                  end else begin
                     out_x_ff    <= job_out.fin_x;
                     out_y_ff    <= job_out.fin_y;
                     num_ff      <= job_out.fin_num;
                     last_ff     <= 1'b1;
                     fin_pend_ff <= 1'b0;
                  end
                  state_ff <= B_SEND;
               end
            end
            B_MUL0: begin
               plo_x_ff <= job_ff.mag_x * s_ff[LO_W-1:0];
               phi_x_ff <= job_ff.mag_x * s_ff[TOT_W-1:LO_W];
               plo_y_ff <= job_ff.mag_y * s_ff[LO_W-1:0];
               phi_y_ff <= job_ff.mag_y * s_ff[TOT_W-1:LO_W];
               state_ff <= B_MUL1;
            end
            B_MUL1: begin
               rem_x_ff <= num_x[QUO_W +: LEN_W];
               sh_x_ff  <= num_x[QUO_W-1:0];
               rem_y_ff <= num_y[QUO_W +: LEN_W];
               sh_y_ff  <= num_y[QUO_W-1:0];
               iter_ff  <= 6'(QUO_W - 1);
               state_ff <= B_DIV;
            end
            B_DIV: begin
               rem_x_ff <= gex ? LEN_W'(shx - {1'b0, job_ff.len}) : LEN_W'(shx);
               rem_y_ff <= gey ? LEN_W'(shy - {1'b0, job_ff.len}) : LEN_W'(shy);
               sh_x_ff  <= qx;
               sh_y_ff  <= qy;
               iter_ff  <= iter_ff - 6'd1;
               if (iter_ff == '0) begin
                  out_x_ff     <= job_ff.neg_x ? job_ff.start_x - qx[COORD_W-1:0]
                                               : job_ff.start_x + qx[COORD_W-1:0];
                  out_y_ff     <= job_ff.neg_y ? job_ff.start_y - qy[COORD_W-1:0]
                                               : job_ff.start_y + qy[COORD_W-1:0];
                  is_vertex_ff <= 1'b0;
                  num_ff       <= '0;
                  last_ff      <= (left_ff == CNT_W'(1)) && !fin_pend_ff;
                  left_ff      <= left_ff - CNT_W'(1);
                  s_ff         <= s_ff + TOT_W'(job_ff.step);
                  state_ff     <= B_SEND;
               end
            end
            B_SEND: begin
               if (rsp.ready) begin
                  if (left_ff != '0) begin
                     state_ff <= B_MUL0;
                  end else if (fin_pend_ff) begin
                     out_x_ff     <= job_ff.fin_x;
                     out_y_ff     <= job_ff.fin_y;
                     num_ff       <= job_ff.fin_num;
                     is_vertex_ff <= 1'b1;
                     last_ff      <= 1'b1;
                     fin_pend_ff  <= 1'b0;
                  end else begin
                     state_ff <= B_IDLE;
                  end
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule
